FILE: src/plc_pkg.sv
// ----------------------------------------------------------------------------
// plc_pkg
// Shared types and constants for the positional list core: field widths,
// operation and status codes, and the command word from controller to datapath.
// ----------------------------------------------------------------------------
package plc_pkg;

  // Default number of slots in the list.
  localparam int DEF_CAPACITY = 16;

  // Fixed field widths.
  localparam int VALUE_W = 32;
  localparam int POS_W   = 8;
  localparam int LEN_W   = 7;

  // Operation codes carried by the mode field.
  typedef enum logic [1:0] {
    MODE_INSERT  = 2'd0,
    MODE_DELETE  = 2'd1,
    MODE_DISPLAY = 2'd2
  } mode_t;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_BADPOS = 2'd1,
    ST_EMPTY  = 2'd2,
    ST_FULL   = 2'd3
  } status_t;

  // Command from the controller to the slot chain.
  typedef struct packed {
    logic               ins;
    logic               del;
    logic               rot;
    logic [VALUE_W-1:0] value;
  } cmd_t;

endpackage

FILE: src/plc_datapath.sv
// ----------------------------------------------------------------------------
// plc_datapath
// Chain of slot cells holding the list, head first, with its entry count.
// Insert and delete shift the tail of the chain; rotate moves
// every live entry down by one and wraps the head round to the tail.
// ----------------------------------------------------------------------------
module plc_datapath #(
  parameter int CAPACITY = plc_pkg::DEF_CAPACITY
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  plc_pkg::cmd_t                         cmd,
  input  logic [$clog2(CAPACITY)-1:0]           idx,
  output logic [$clog2(CAPACITY+1)-1:0]         count,
  output logic [plc_pkg::VALUE_W-1:0]           head
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int IW = $clog2(CAPACITY);

  logic [plc_pkg::VALUE_W-1:0] slots [CAPACITY];

  assign head = slots[0];

  // Each cell picks its next value from itself, its neighbours, the insert value or the head.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    always_ff @(posedge clk) begin
      if (cmd.ins) begin
        if (IW'(i) == idx) begin
          slots[i] <= cmd.value;
        end else if (IW'(i) > idx) begin
          if (i > 0) begin
            slots[i] <= slots[(i > 0) ? i - 1 : 0];
          end
        end
      end else if (cmd.del) begin
        if (IW'(i) >= idx) begin
          if (i + 1 < CAPACITY) begin
            slots[i] <= slots[(i + 1 < CAPACITY) ? i + 1 : i];
          end
        end
      end else if (cmd.rot) begin
        if (CW'(i + 1) == count) begin
          slots[i] <= slots[0];
        end else if (i + 1 < CAPACITY) begin
          slots[i] <= slots[(i + 1 < CAPACITY) ? i + 1 : i];
        end
      end
    end
  end

  // Entry count.
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.ins) begin
      count <= count + CW'(1);
    end else if (cmd.del) begin
      count <= count - CW'(1);
    end
  end

endmodule

FILE: src/plc_ctrl.sv
// ----------------------------------------------------------------------------
// plc_ctrl
// Controller for the positional list: checks each input word against the
// current count, issues insert, delete and rotate commands, and holds the
// result word until it is taken.
// ----------------------------------------------------------------------------
module plc_ctrl #(
  parameter int CAPACITY = plc_pkg::DEF_CAPACITY
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic [1:0]                            mode,
  input  logic [plc_pkg::VALUE_W-1:0]           value,
  input  logic [plc_pkg::POS_W-1:0]             position,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic [1:0]                            status,
  output logic [plc_pkg::VALUE_W-1:0]           entry,
  output logic                                  last,
  input  logic [$clog2(CAPACITY+1)-1:0]         count,
  input  logic [plc_pkg::VALUE_W-1:0]           head,
  output plc_pkg::cmd_t                         cmd,
  output logic [$clog2(CAPACITY)-1:0]           idx
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int IW = $clog2(CAPACITY);

  typedef enum logic [1:0] {
    S_IDLE,
    S_RESP,
    S_DISP
  } state_t;

  state_t           state;
  plc_pkg::status_t status_q;
  logic [CW-1:0]    disp_idx;

  logic             accept;
  logic [8:0]       cnt9;
  logic [8:0]       pos9;
  logic             ins_ok;
  logic             full;
  logic             del_ok;
  logic             disp_last;
  plc_pkg::status_t resp_status;

  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && (state == S_IDLE);

  // Position checks against the current count.
  assign cnt9   = 9'(count);
  assign pos9   = 9'(position);
  assign ins_ok = (position != '0) && (pos9 <= cnt9 + 9'd1);
  assign full   = (cnt9 == 9'(CAPACITY));
  assign del_ok = (count != '0) && (position != '0) && (pos9 <= cnt9);

  // Status of a single-word result.
  always_comb begin
    case (mode)
      plc_pkg::MODE_INSERT: begin
        if (!ins_ok) begin
          resp_status = plc_pkg::ST_BADPOS;
        end else if (full) begin
          resp_status = plc_pkg::ST_FULL;
        end else begin
          resp_status = plc_pkg::ST_OK;
        end
      end
      plc_pkg::MODE_DELETE: begin
        if (count == '0) begin
          resp_status = plc_pkg::ST_EMPTY;
        end else if (!del_ok) begin
          resp_status = plc_pkg::ST_BADPOS;
        end else begin
          resp_status = plc_pkg::ST_OK;
        end
      end
      plc_pkg::MODE_DISPLAY: begin
        resp_status = plc_pkg::ST_EMPTY;
      end
      default: begin
        resp_status = plc_pkg::ST_BADPOS;
      end
    endcase
  end

  // Commands to the slot chain.
  assign cmd.ins   = accept && (mode == plc_pkg::MODE_INSERT) && ins_ok && !full;
  assign cmd.del   = accept && (mode == plc_pkg::MODE_DELETE) && del_ok;
  assign cmd.rot   = (state == S_DISP) && !out_stall;
  assign cmd.value = value;
  assign idx       = IW'(position - 8'd1);

  assign disp_last = ((disp_idx + CW'(1)) == count);

  // State and result registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      disp_idx <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            if ((mode == plc_pkg::MODE_DISPLAY) && (count != '0)) begin
              state    <= S_DISP;
              disp_idx <= '0;
            end else begin
              state    <= S_RESP;
              status_q <= resp_status;
            end
          end
        end
        S_RESP: begin
          if (!out_stall) begin
            state <= S_IDLE;
          end
        end
        S_DISP: begin
          if (!out_stall) begin
            if (disp_last) begin
              state <= S_IDLE;
            end else begin
              disp_idx <= disp_idx + CW'(1);
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Result word: display streams the head of the chain as it rotates.
  assign out_valid = (state != S_IDLE);
  assign status    = (state == S_DISP) ? plc_pkg::ST_OK : status_q;
  assign entry     = (state == S_DISP) ? head : '0;
  assign last      = (state == S_DISP) ? disp_last : 1'b1;

endmodule

FILE: src/positional_list_insert_delete_core.sv
// ----------------------------------------------------------------------------
// positional_list_insert_delete_core
// Ordered list of signed 32-bit values with insert, delete and display.
// ----------------------------------------------------------------------------
// The block works on one input word at a time. When an insert, delete or
// rejected word is taken, the slot chain shifts in parallel, and its single
// result word appears on the next cycle; the next input word is taken once
// that result has been accepted. A display of a list of n entries streams n
// result words, one per cycle while the output is not stalled, by rotating
// the slot chain one place per word; an empty list gives a single word.
// The result length is the entry count after the operation, and entry is
// zero in every word that is not a displayed entry.
module positional_list_insert_delete_core #(
  parameter int CAPACITY = plc_pkg::DEF_CAPACITY
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic [1:0]                            mode,
  input  logic signed [plc_pkg::VALUE_W-1:0]    value,
  input  logic [plc_pkg::POS_W-1:0]             position,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic [1:0]                            status,
  output logic signed [plc_pkg::VALUE_W-1:0]    entry,
  output logic [plc_pkg::LEN_W-1:0]             length,
  output logic                                  last
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int IW = $clog2(CAPACITY);

  plc_pkg::cmd_t               cmd;
  logic [IW-1:0]               idx;
  logic [CW-1:0]               count;
  logic [plc_pkg::VALUE_W-1:0] head;

  // Controller.
  plc_ctrl #(
    .CAPACITY (CAPACITY)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .mode      (mode),
    .value     (value),
    .position  (position),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .entry     (entry),
    .last      (last),
    .count     (count),
    .head      (head),
    .cmd       (cmd),
    .idx       (idx)
  );

  // Slot chain.
  plc_datapath #(
    .CAPACITY (CAPACITY)
  ) u_datapath (
    .clk   (clk),
    .rst   (rst),
    .cmd   (cmd),
    .idx   (idx),
    .count (count),
    .head  (head)
  );

  assign length = plc_pkg::LEN_W'(count);

  // No new word is taken while a result word is pending.
  a_no_accept_while_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall)
    else $error("input accepted while a result word is pending");

  // The entry count never exceeds the capacity.
  a_len_bound: assert property (@(posedge clk) disable iff (rst)
    length <= CAPACITY)
    else $error("list length above capacity");

  // Result words with an error status carry a zero entry field.
  a_entry_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (status != plc_pkg::ST_OK)) |-> (entry == '0))
    else $error("non-zero entry on an error result");

  // Once the final word of an item is taken, the output goes quiet.
  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_stall && last) |=> !out_valid)
    else $error("result word after the final word of an item");

endmodule
